// ===== src/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, constants and width helpers for the vertex rotation and
// projection pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

	// fraction bits of model coordinates, default
	localparam int FRAC_BITS_DEF = 12;

	// register reset values
	localparam logic [15:0] COS_RESET      = 16'd16384;
	localparam logic [15:0] SIN_RESET      = 16'd0;
	localparam logic [14:0] OFFSET_RESET   = 15'd12288;
	localparam logic [9:0]  SCALE_RESET    = 10'd240;
	localparam logic [10:0] CENTER_X_RESET = 11'd320;
	localparam logic [10:0] CENTER_Y_RESET = 11'd240;

	// fixed datapath widths
	localparam int ROT_FRAC   = 14;
	localparam int COORD_W    = 22;
	localparam int QUO_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS      = 3'd0,
		REG_SIN      = 3'd1,
		REG_OFFSET   = 3'd2,
		REG_SCALE    = 3'd3,
		REG_CENTER_X = 3'd4,
		REG_CENTER_Y = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] cos_angle;
		logic signed [15:0] sin_angle;
		logic [14:0]        depth_offset;
		logic [9:0]         screen_scale;
		logic [10:0]        center_x;
		logic [10:0]        center_y;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic               last_corner;
	} vertex_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [15:0]        inverse_depth;
		logic [15:0]        out_u;
		logic [15:0]        out_v;
		logic               strip_end;
		logic               depth_fault;
	} screen_t;

	// fields that ride along the divider
	typedef struct packed {
		logic        neg_x;
		logic        neg_y;
		logic        fault;
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic        last;
	} side_t;

	typedef struct packed {
		logic [QUO_W-1:0] q_x;
		logic [QUO_W-1:0] q_y;
		logic [QUO_W-1:0] q_i;
		logic             ovf_x;
		logic             ovf_y;
		logic             ovf_i;
	} div_res_t;

	// aligned depth offset width
	function automatic int off_w(input int frac);
		return (frac >= 12) ? 15 + frac - 12 : 15 - (12 - frac);
	endfunction

	// signed offset depth width
	function automatic int depth_w(input int frac);
		int o;
		o = off_w(frac) + 1;
		return ((o > COORD_W) ? o : COORD_W) + 1;
	endfunction

	// signed projection numerator width
	function automatic int pn_w(input int frac);
		int p;
		p = COORD_W + 11 + 5;
		return ((p > depth_w(frac)) ? p : depth_w(frac)) + 1;
	endfunction

	// unsigned dividend width
	function automatic int num_w(input int frac);
		int p;
		p = pn_w(frac) - 1;
		return (p > frac + 16) ? p : frac + 16;
	endfunction

endpackage

// ===== src/vrp_rotate.sv =====
// ----------------------------------------------------------------------------
// vrp_rotate
// Rotation about Y then X, followed by the depth offset, in four stages.
// ----------------------------------------------------------------------------
module vrp_rotate #(
	parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF,
	localparam int DEPTH_W = vrp_pkg::depth_w(FRAC_BITS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  vrp_pkg::vertex_t                   in_data,
	input  vrp_pkg::cfg_t                      cfg,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [vrp_pkg::COORD_W-1:0] coord_x,
	output logic signed [vrp_pkg::COORD_W-1:0] coord_y,
	output logic signed [DEPTH_W-1:0]          depth,
	output vrp_pkg::side_t                     side
);

	localparam int OFF_W   = vrp_pkg::off_w(FRAC_BITS);
	localparam int SH_L    = (FRAC_BITS >= 12) ? FRAC_BITS - 12 : 0;
	localparam int SH_R    = (FRAC_BITS >= 12) ? 0 : 12 - FRAC_BITS;
	localparam int ALIGN_W = 15 + SH_L;
	localparam int CW      = vrp_pkg::COORD_W;
	localparam int RF      = vrp_pkg::ROT_FRAC;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [31:0] pxc_s1, pzs_s1, pxs_s1, pzc_s1;
	logic signed [15:0] y0_s1, y0_s2;
	vrp_pkg::side_t     side_s1, side_s2, side_s3, side_s4;

	logic signed [18:0] x1_s2, z1_s2, x1_s3;
	logic signed [31:0] pyc_s3, pys_s3;
	logic signed [34:0] pz1s_s3, pz1c_s3;

	logic signed [CW-1:0]      x1_s4, y_s4;
	logic signed [DEPTH_W-1:0] depth_s4;

	logic signed [32:0]        sum_x, sum_z1;
	logic signed [35:0]        sum_y, sum_z;
	logic signed [CW-1:0]      z_rot;
	logic [OFF_W-1:0]          off;
	vrp_pkg::side_t            side_in;

	// stall chain
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// sideband from the input transaction
	always_comb begin
		side_in       = '0;
		side_in.tex_u = in_data.tex_u;
		side_in.tex_v = in_data.tex_v;
		side_in.last  = in_data.last_corner;
	end

	// rounded sums of both rotations and the offset depth
	always_comb begin
		sum_x  = 33'(pxc_s1) - 33'(pzs_s1) + 33'sd8192;
		sum_z1 = 33'(pxs_s1) + 33'(pzc_s1) + 33'sd8192;
		sum_y  = 36'(pyc_s3) - 36'(pz1s_s3) + 36'sd8192;
		sum_z  = 36'(pys_s3) + 36'(pz1c_s3) + 36'sd8192;
		z_rot  = CW'(sum_z >>> RF);
		off    = OFF_W'((ALIGN_W'(cfg.depth_offset) << SH_L) >> SH_R);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// data stages
	always_ff @(posedge clk) begin
		if (en1) begin
			pxc_s1  <= in_data.pos_x * cfg.cos_angle;
			pzs_s1  <= in_data.pos_z * cfg.sin_angle;
			pxs_s1  <= in_data.pos_x * cfg.sin_angle;
			pzc_s1  <= in_data.pos_z * cfg.cos_angle;
			y0_s1   <= in_data.pos_y;
			side_s1 <= side_in;
		end
		if (en2) begin
			x1_s2   <= 19'(sum_x >>> RF);
			z1_s2   <= 19'(sum_z1 >>> RF);
			y0_s2   <= y0_s1;
			side_s2 <= side_s1;
		end
		if (en3) begin
			pyc_s3  <= y0_s2 * cfg.cos_angle;
			pz1s_s3 <= z1_s2 * cfg.sin_angle;
			pys_s3  <= y0_s2 * cfg.sin_angle;
			pz1c_s3 <= z1_s2 * cfg.cos_angle;
			x1_s3   <= x1_s2;
			side_s3 <= side_s2;
		end
		if (en4) begin
			x1_s4    <= CW'(x1_s3);
			y_s4     <= CW'(sum_y >>> RF);
			depth_s4 <= DEPTH_W'(z_rot) + DEPTH_W'(off);
			side_s4  <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign coord_x   = x1_s4;
	assign coord_y   = y_s4;
	assign depth     = depth_s4;
	assign side      = side_s4;

endmodule

// ===== src/vrp_setup.sv =====
// ----------------------------------------------------------------------------
// vrp_setup
// Scales the coordinates and forms dividends and divisor for the divider.
// ----------------------------------------------------------------------------
module vrp_setup #(
	parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF,
	localparam int DEPTH_W = vrp_pkg::depth_w(FRAC_BITS),
	localparam int NUM_W   = vrp_pkg::num_w(FRAC_BITS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [vrp_pkg::COORD_W-1:0] coord_x,
	input  logic signed [vrp_pkg::COORD_W-1:0] coord_y,
	input  logic signed [DEPTH_W-1:0]          depth,
	input  vrp_pkg::side_t                     side_in,
	input  vrp_pkg::cfg_t                      cfg,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [NUM_W-1:0]                   num_x,
	output logic [NUM_W-1:0]                   num_y,
	output logic [NUM_W-1:0]                   num_i,
	output logic [DEPTH_W-1:0]                 den,
	output vrp_pkg::side_t                     side_out
);

	localparam int PN_W = vrp_pkg::pn_w(FRAC_BITS);
	localparam int PW   = vrp_pkg::COORD_W + 11;

	logic v_s1, v_s2, en1, en2;

	logic signed [PW-1:0]      px_s1, py_s1;
	logic signed [DEPTH_W-1:0] depth_s1;
	vrp_pkg::side_t            side_s1, side_s2;

	logic [NUM_W-1:0]   tx_s2, ty_s2, ti_s2;
	logic [DEPTH_W-1:0] den_s2;

	logic signed [PN_W-1:0] nx, ny;
	logic signed [PN_W-1:0] mx, my;
	vrp_pkg::side_t         side_nx;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// rounded dividends: 32 * coord * scale + depth, folded to magnitude
	always_comb begin
		nx              = (PN_W'(px_s1) <<< 5) + PN_W'(depth_s1);
		ny              = (PN_W'(py_s1) <<< 5) + PN_W'(depth_s1);
		mx              = nx[PN_W-1] ? ~nx : nx;
		my              = ny[PN_W-1] ? ~ny : ny;
		side_nx         = side_s1;
		side_nx.neg_x   = nx[PN_W-1];
		side_nx.neg_y   = ny[PN_W-1];
		side_nx.fault   = depth_s1[DEPTH_W-1] || (depth_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1    <= coord_x * $signed({1'b0, cfg.screen_scale});
			py_s1    <= coord_y * $signed({1'b0, cfg.screen_scale});
			depth_s1 <= depth;
			side_s1  <= side_in;
		end
		if (en2) begin
			tx_s2   <= NUM_W'(mx);
			ty_s2   <= NUM_W'(my);
			ti_s2   <= (NUM_W'(1) << (FRAC_BITS + 15)) +
				NUM_W'(depth_s1[DEPTH_W-2:0]);
			den_s2  <= {depth_s1[DEPTH_W-2:0], 1'b0};
			side_s2 <= side_nx;
		end
	end

	assign out_valid = v_s2;
	assign num_x     = tx_s2;
	assign num_y     = ty_s2;
	assign num_i     = ti_s2;
	assign den       = den_s2;
	assign side_out  = side_s2;

endmodule

// ===== src/vrp_divide.sv =====
// ----------------------------------------------------------------------------
// vrp_divide
// Three-lane restoring divider with a shared divisor, one quotient bit per
// stage, with an overflow check ahead of the first step.
// ----------------------------------------------------------------------------
module vrp_divide #(
	parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF,
	localparam int DEN_W = vrp_pkg::depth_w(FRAC_BITS),
	localparam int NUM_W = vrp_pkg::num_w(FRAC_BITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [NUM_W-1:0]   num_x,
	input  logic [NUM_W-1:0]   num_y,
	input  logic [NUM_W-1:0]   num_i,
	input  logic [DEN_W-1:0]   den,
	input  vrp_pkg::side_t     side_in,
	output logic               out_valid,
	input  logic               out_ready,
	output vrp_pkg::div_res_t  res,
	output vrp_pkg::side_t     side_out
);

	localparam int QW    = vrp_pkg::QUO_W;
	localparam int NS    = QW + 1;
	localparam int HI_W  = NUM_W - QW;
	localparam int CMP_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
	localparam int LANES = 3;

	logic                 v_s   [NS];
	logic                 en    [NS];
	logic [DEN_W-1:0]     rem_s [NS][LANES];
	logic [QW-1:0]        w_s   [NS][LANES];
	logic [LANES-1:0]     ovf_s [NS];
	logic [DEN_W-1:0]     den_s [NS];
	vrp_pkg::side_t       side_s[NS];

	logic [DEN_W-1:0]     rem_n [NS][LANES];
	logic [QW-1:0]        w_n   [NS][LANES];
	logic [LANES-1:0]     ovf_n;
	logic [NUM_W-1:0]     num   [LANES];
	logic [CMP_W-1:0]     hi;
	logic [DEN_W:0]       r2;
	logic                 ge;

	// stall chain, last stage first
	always_comb begin
		en[NS-1] = !v_s[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end
	assign in_ready = en[0];

	// overflow check and one restoring step per stage
	always_comb begin
		num[0] = num_x;
		num[1] = num_y;
		num[2] = num_i;
		ovf_n  = '0;
		hi     = '0;
		r2     = '0;
		ge     = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			hi          = CMP_W'(num[l] >> QW);
			ovf_n[l]    = hi >= CMP_W'(den);
			rem_n[0][l] = DEN_W'(hi);
			w_n[0][l]   = num[l][QW-1:0];
		end
		for (int k = 1; k < NS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				r2          = {rem_s[k-1][l], w_s[k-1][l][QW-1]};
				ge          = r2 >= {1'b0, den_s[k-1]};
				rem_n[k][l] = ge ? DEN_W'(r2 - {1'b0, den_s[k-1]}) : DEN_W'(r2);
				w_n[k][l]   = {w_s[k-1][l][QW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) v_s[k] <= 1'b0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ovf_s[0]  <= ovf_n;
			den_s[0]  <= den;
			side_s[0] <= side_in;
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= rem_n[0][l];
				w_s[0][l]   <= w_n[0][l];
			end
		end
		for (int k = 1; k < NS; k++) begin
			if (en[k]) begin
				ovf_s[k]  <= ovf_s[k-1];
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= rem_n[k][l];
					w_s[k][l]   <= w_n[k][l];
				end
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign side_out  = side_s[NS-1];
	always_comb begin
		res.q_x   = w_s[NS-1][0];
		res.q_y   = w_s[NS-1][1];
		res.q_i   = w_s[NS-1][2];
		res.ovf_x = ovf_s[NS-1][0];
		res.ovf_y = ovf_s[NS-1][1];
		res.ovf_i = ovf_s[NS-1][2];
	end

endmodule

// ===== src/vrp_finish.sv =====
// ----------------------------------------------------------------------------
// vrp_finish
// Signs the quotients, centres and saturates them, and holds the result in
// the output register.
// ----------------------------------------------------------------------------
module vrp_finish (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  vrp_pkg::div_res_t res,
	input  vrp_pkg::side_t    side_in,
	input  vrp_pkg::cfg_t     cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output vrp_pkg::screen_t  out_data
);

	localparam int QW = vrp_pkg::QUO_W;

	logic             v_q;
	vrp_pkg::screen_t res_q;
	vrp_pkg::screen_t res_n;

	// floor quotient plus centre, clamped to 16 bits
	function automatic logic [15:0] place(input logic [QW-1:0] q, input logic ovf,
		input logic neg, input logic [10:0] center);
		logic [QW-1:0]        qu;
		logic signed [QW:0]   qs;
		logic signed [QW+1:0] s;
		logic [15:0]          r;
		qu = ovf ? '1 : q;
		qs = neg ? ~$signed({1'b0, qu}) : $signed({1'b0, qu});
		s  = (QW+2)'(qs) + $signed((QW+2)'({center, 4'b0000}));
		if (s > $signed((QW+2)'(32767))) begin
			r = 16'h7FFF;
		end else if (s < -$signed((QW+2)'(32768))) begin
			r = 16'h8000;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

	always_comb begin
		res_n.screen_x      = place(res.q_x, res.ovf_x, side_in.neg_x, cfg.center_x);
		res_n.screen_y      = place(res.q_y, res.ovf_y, side_in.neg_y, cfg.center_y);
		res_n.inverse_depth = (res.ovf_i || res.q_i[QW-1]) ? 16'hFFFF : res.q_i[15:0];
		res_n.out_u         = side_in.tex_u;
		res_n.out_v         = side_in.tex_v;
		res_n.strip_end     = side_in.last;
		res_n.depth_fault   = side_in.fault;
		// no projection when depth is not positive
		if (side_in.fault) begin
			res_n.screen_x      = '0;
			res_n.screen_y      = '0;
			res_n.inverse_depth = '0;
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) res_q <= res_n;
	end

	assign out_valid = v_q;
	assign out_data  = res_q;

endmodule

// ===== src/vertex_rotate_project_top.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_top
// Vertex rotation and perspective projection to screen pixels.
// ----------------------------------------------------------------------------
// stages from accepted input to output valid: 4 rotate, 2 setup, 18 divider
//   stages (an overflow check, then one quotient bit each), 1 output register
// throughput: one vertex per cycle; a stage stalls only when the one after
//   it holds an item that cannot move on, so bubbles are squeezed out
// reset: arst_n clears all valid bits and loads the register defaults
module vertex_rotate_project_top #(
	parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  vrp_pkg::vertex_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output vrp_pkg::screen_t                 out_data,
	input  logic                             cfg_write,
	input  logic [vrp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vrp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int DEPTH_W = vrp_pkg::depth_w(FRAC_BITS);
	localparam int NUM_W   = vrp_pkg::num_w(FRAC_BITS);

	vrp_pkg::cfg_t cfg_q;

	logic                               rot_valid, rot_ready;
	logic signed [vrp_pkg::COORD_W-1:0] rot_x, rot_y;
	logic signed [DEPTH_W-1:0]          rot_depth;
	vrp_pkg::side_t                     rot_side;

	logic               set_valid, set_ready;
	logic [NUM_W-1:0]   set_nx, set_ny, set_ni;
	logic [DEPTH_W-1:0] set_den;
	vrp_pkg::side_t     set_side;

	logic              div_valid, div_ready;
	vrp_pkg::div_res_t div_res;
	vrp_pkg::side_t    div_side;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_angle    <= vrp_pkg::COS_RESET;
			cfg_q.sin_angle    <= vrp_pkg::SIN_RESET;
			cfg_q.depth_offset <= vrp_pkg::OFFSET_RESET;
			cfg_q.screen_scale <= vrp_pkg::SCALE_RESET;
			cfg_q.center_x     <= vrp_pkg::CENTER_X_RESET;
			cfg_q.center_y     <= vrp_pkg::CENTER_Y_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				vrp_pkg::REG_COS:      cfg_q.cos_angle    <= cfg_data;
				vrp_pkg::REG_SIN:      cfg_q.sin_angle    <= cfg_data;
				vrp_pkg::REG_OFFSET:   cfg_q.depth_offset <= cfg_data[14:0];
				vrp_pkg::REG_SCALE:    cfg_q.screen_scale <= cfg_data[9:0];
				vrp_pkg::REG_CENTER_X: cfg_q.center_x     <= cfg_data[10:0];
				vrp_pkg::REG_CENTER_Y: cfg_q.center_y     <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	vrp_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.coord_x   (rot_x),
		.coord_y   (rot_y),
		.depth     (rot_depth),
		.side      (rot_side)
	);

	vrp_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.in_ready  (rot_ready),
		.coord_x   (rot_x),
		.coord_y   (rot_y),
		.depth     (rot_depth),
		.side_in   (rot_side),
		.cfg       (cfg_q),
		.out_valid (set_valid),
		.out_ready (set_ready),
		.num_x     (set_nx),
		.num_y     (set_ny),
		.num_i     (set_ni),
		.den       (set_den),
		.side_out  (set_side)
	);

	vrp_divide #(.FRAC_BITS(FRAC_BITS)) u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (set_valid),
		.in_ready  (set_ready),
		.num_x     (set_nx),
		.num_y     (set_ny),
		.num_i     (set_ni),
		.den       (set_den),
		.side_in   (set_side),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.res       (div_res),
		.side_out  (div_side)
	);

	vrp_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.in_ready  (div_ready),
		.res       (div_res),
		.side_in   (div_side),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex rotation and projection pipeline:
// random and directed vertices under random stalls on both channels, with
// register settings changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FB = vrp_pkg::FRAC_BITS_DEF;
	localparam int PIPE_LAT = 25;

	// scoreboard: predicts projected vertices and holds them until they come out
	class screen_board;
		logic signed [15:0] cos_q, sin_q;
		logic [14:0] offset_q;
		logic [9:0]  scale_q;
		logic [10:0] cx_q, cy_q;
		vrp_pkg::screen_t pending[$];
		int errors;

		function new();
			cos_q = vrp_pkg::COS_RESET; sin_q = vrp_pkg::SIN_RESET;
			offset_q = vrp_pkg::OFFSET_RESET; scale_q = vrp_pkg::SCALE_RESET;
			cx_q = vrp_pkg::CENTER_X_RESET; cy_q = vrp_pkg::CENTER_Y_RESET;
			errors = 0;
		endfunction

		function void set_reg(vrp_pkg::cfg_reg_t idx, logic [15:0] val);
			case (idx)
				vrp_pkg::REG_COS: cos_q = val;
				vrp_pkg::REG_SIN: sin_q = val;
				vrp_pkg::REG_OFFSET: offset_q = val[14:0];
				vrp_pkg::REG_SCALE: scale_q = val[9:0];
				vrp_pkg::REG_CENTER_X: cx_q = val[10:0];
				vrp_pkg::REG_CENTER_Y: cy_q = val[10:0];
				default: ;
			endcase
		endfunction

		// floor division with positive divisor
		function longint fdiv(longint n, longint d);
			if (n >= 0) return n / d;
			return -((-n + d - 1) / d);
		endfunction

		function longint rnd14(longint v);
			return fdiv(v + 8192, 16384);
		endfunction

		function logic [15:0] to_pixel(longint coord, longint depth, logic [10:0] ctr);
			longint num, q;
			num = coord * longint'(scale_q) * 16;
			q = fdiv(2 * num + depth, 2 * depth) + longint'(ctr) * 16;
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			return q[15:0];
		endfunction

		function void note_vertex(vrp_pkg::vertex_t v);
			longint c, s, x1, z1, y, z, off, depth, inv;
			vrp_pkg::screen_t r;
			c = cos_q; s = sin_q;
			x1 = rnd14(longint'(v.pos_x) * c - longint'(v.pos_z) * s);
			z1 = rnd14(longint'(v.pos_x) * s + longint'(v.pos_z) * c);
			y = rnd14(longint'(v.pos_y) * c - z1 * s);
			z = rnd14(longint'(v.pos_y) * s + z1 * c);
			off = (FB >= 12) ? (longint'(offset_q) << (FB - 12)) :
				(longint'(offset_q) >> (12 - FB));
			depth = z + off;
			r.out_u = v.tex_u;
			r.out_v = v.tex_v;
			r.strip_end = v.last_corner;
			if (depth <= 0) begin
				r.screen_x = '0; r.screen_y = '0; r.inverse_depth = '0;
				r.depth_fault = 1'b1;
			end else begin
				inv = ((longint'(1) << (FB + 15)) + depth) / (2 * depth);
				r.screen_x = to_pixel(x1, depth, cx_q);
				r.screen_y = to_pixel(y, depth, cy_q);
				r.inverse_depth = (inv > 65535) ? 16'hFFFF : inv[15:0];
				r.depth_fault = 1'b0;
			end
			pending.push_back(r);
		endfunction

		function void check_screen(vrp_pkg::screen_t a);
			vrp_pkg::screen_t e;
			if (pending.size() == 0) begin
				$error("unexpected output transaction %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.screen_x !== e.screen_x) begin
				$error("screen_x exp %0d got %0d", e.screen_x, a.screen_x); errors++;
			end
			if (a.screen_y !== e.screen_y) begin
				$error("screen_y exp %0d got %0d", e.screen_y, a.screen_y); errors++;
			end
			if (a.inverse_depth !== e.inverse_depth) begin
				$error("inverse_depth exp %0d got %0d", e.inverse_depth, a.inverse_depth);
				errors++;
			end
			if (a.out_u !== e.out_u) begin
				$error("out_u exp %0d got %0d", e.out_u, a.out_u); errors++;
			end
			if (a.out_v !== e.out_v) begin
				$error("out_v exp %0d got %0d", e.out_v, a.out_v); errors++;
			end
			if (a.strip_end !== e.strip_end) begin
				$error("strip_end exp %0b got %0b", e.strip_end, a.strip_end);
				errors++;
			end
			if (a.depth_fault !== e.depth_fault) begin
				$error("depth_fault exp %0b got %0b", e.depth_fault, a.depth_fault);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	vrp_pkg::vertex_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	vrp_pkg::screen_t out_data;
	logic cfg_write = 0;
	logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [vrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic sink_on = 0;

	screen_board board = new();

	vertex_rotate_project_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// run limit
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

	// output side: random stalls, check on each transaction
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (!sink_on) begin
				out_ready <= 0;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				if ($urandom_range(0, 5) == 0) gap = 0;
				repeat (gap) begin
					out_ready <= 0;
					@(negedge clk);
				end
				out_ready <= 1;
				@(posedge clk);
				while (!out_valid) @(posedge clk);
				board.check_screen(out_data);
			end
		end
	end

	task automatic write_reg(vrp_pkg::cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_write <= 0;
	endtask

	// valid stays high into the next transaction when no gap is drawn
	task automatic send_vertex(vrp_pkg::vertex_t v, bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_vertex(v);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	function automatic vrp_pkg::vertex_t rand_vertex(int mode);
		vrp_pkg::vertex_t v;
		v.pos_x = 16'($urandom); v.pos_y = 16'($urandom); v.pos_z = 16'($urandom);
		if (mode == 1) begin
			// stay in the unit-ish cube so most depths are positive
			v.pos_x = 16'($signed($urandom_range(0, 16383)) - 8192);
			v.pos_y = 16'($signed($urandom_range(0, 16383)) - 8192);
			v.pos_z = 16'($signed($urandom_range(0, 16383)) - 8192);
		end
		v.tex_u = 16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32768));
		v.tex_v = 16'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32768));
		v.last_corner = 1'($urandom);
		return v;
	endfunction

	task automatic random_phase(int count);
		bit burst;
		int i;
		for (i = 0; i < count; i++) begin
			if (i % 50 == 0) burst = ($urandom_range(0, 2) == 0);
			send_vertex(rand_vertex($urandom_range(0, 3) != 0), burst);
		end
	endtask

	function automatic vrp_pkg::vertex_t mk(logic [15:0] x, logic [15:0] y, logic [15:0] z,
		logic [15:0] u, logic [15:0] w, logic l);
		vrp_pkg::vertex_t v;
		v.pos_x = x; v.pos_y = y; v.pos_z = z;
		v.tex_u = u; v.tex_v = w; v.last_corner = l;
		return v;
	endfunction

	initial begin
		int p;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		sink_on <= 1;

		// directed: field extremes, zero and negative depth, saturation
		send_vertex(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0);
		send_vertex(mk(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1), 1'b0);
		send_vertex(mk(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0), 1'b0);
		send_vertex(mk(16'h7FFF, 16'h8000, 16'hD000, 16'h1234, 16'h4321, 1'b1), 1'b0);
		send_vertex(mk(16'h1000, 16'hF000, 16'hD001, 16'h0001, 16'h7FFF, 1'b0), 1'b1);
		send_vertex(mk(16'h8000, 16'h7FFF, 16'hCFFF, 16'h5555, 16'hAAAA, 1'b1), 1'b1);
		send_vertex(mk(16'h0800, 16'h0800, 16'hC000, 16'h0000, 16'h8000, 1'b0), 1'b0);
		send_vertex(mk(16'hF800, 16'h0400, 16'h1000, 16'h8000, 16'h0000, 1'b1), 1'b0);
		drain();

		// extreme settings: zero cosine, a sine of minus one, largest offset and scale
		write_reg(vrp_pkg::REG_COS, 16'h0000);
		write_reg(vrp_pkg::REG_SIN, 16'hC000);
		write_reg(vrp_pkg::REG_OFFSET, 16'h7FFF);
		write_reg(vrp_pkg::REG_SCALE, 16'h03FF);
		write_reg(vrp_pkg::REG_CENTER_X, 16'h07FF);
		write_reg(vrp_pkg::REG_CENTER_Y, 16'h0000);
		send_vertex(mk(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0, 16'h1, 1'b1), 1'b0);
		send_vertex(mk(16'h8000, 16'h7FFF, 16'h8000, 16'h2, 16'h3, 1'b0), 1'b0);
		random_phase(150);
		drain();

		write_reg(vrp_pkg::REG_COS, 16'h8000);
		write_reg(vrp_pkg::REG_SIN, 16'h7FFF);
		write_reg(vrp_pkg::REG_OFFSET, 16'h0000);
		write_reg(vrp_pkg::REG_SCALE, 16'h0000);
		write_reg(vrp_pkg::REG_CENTER_X, 16'h0000);
		write_reg(vrp_pkg::REG_CENTER_Y, 16'h07FF);
		send_vertex(mk(16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'h8000, 1'b1), 1'b0);
		send_vertex(mk(16'h0000, 16'h0000, 16'hFFFF, 16'h0, 16'h0, 1'b0), 1'b0);
		random_phase(150);
		drain();

		// a run of random settings
		for (p = 0; p < 10; p++) begin
			write_reg(vrp_pkg::REG_COS, 16'(($urandom_range(0, 4) == 0) ? $urandom :
				$signed($urandom_range(0, 32768)) - 16384));
			write_reg(vrp_pkg::REG_SIN, 16'(($urandom_range(0, 4) == 0) ? $urandom :
				$signed($urandom_range(0, 32768)) - 16384));
			write_reg(vrp_pkg::REG_OFFSET, 16'(($urandom_range(0, 2) == 0) ?
				$urandom_range(0, 32767) : $urandom_range(4096, 20000)));
			write_reg(vrp_pkg::REG_SCALE, 16'($urandom_range(0, 1023)));
			write_reg(vrp_pkg::REG_CENTER_X, 16'($urandom_range(0, 2047)));
			write_reg(vrp_pkg::REG_CENTER_Y, 16'($urandom_range(0, 2047)));
			random_phase(150);
			drain();
		end

		// back to the reset setting
		write_reg(vrp_pkg::REG_COS, vrp_pkg::COS_RESET);
		write_reg(vrp_pkg::REG_SIN, vrp_pkg::SIN_RESET);
		write_reg(vrp_pkg::REG_OFFSET, 16'(vrp_pkg::OFFSET_RESET));
		write_reg(vrp_pkg::REG_SCALE, 16'(vrp_pkg::SCALE_RESET));
		write_reg(vrp_pkg::REG_CENTER_X, 16'(vrp_pkg::CENTER_X_RESET));
		write_reg(vrp_pkg::REG_CENTER_Y, 16'(vrp_pkg::CENTER_Y_RESET));
		random_phase(100);
		drain();

		if (board.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
